@@ hdl/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

  // Fixed field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned IdxW   = 11;
  localparam int unsigned PosW   = 11;
  localparam int unsigned CellW  = 16;
  localparam int unsigned LenW   = 8;
  localparam int unsigned ColorW = 4;
  localparam int unsigned CfgAw  = 1;

  localparam logic [CodeW-1:0]  CodeNewline = 8'h0A;
  localparam logic [CodeW-1:0]  CodeBlank   = 8'h20;
  localparam logic [CellW-1:0]  CellReset   = 16'h0F20;
  localparam logic [ColorW-1:0] FgReset     = 4'hF;
  localparam logic [ColorW-1:0] BgReset     = 4'h0;

  // Configuration register indexes
  localparam logic [CfgAw-1:0] RegForeground = 1'd0;
  localparam logic [CfgAw-1:0] RegBackground = 1'd1;

  typedef enum logic [OpW-1:0] {
    OP_WRITE     = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_e;

endpackage

@@ hdl/text_console_writer_unit.sv @@
`timescale 1ns / 1ps

// Teletype writer for a ROWS x COLUMNS text screen held in one single-port-write,
// one-read memory. After reset the block is busy while it fills the screen with
// blanks (0x0F20); configuration writes are taken meanwhile.
// An operation is taken when start_i is high and busy_o is low; its result shows on
// the output ports for exactly one cycle with done_o high and cannot be held off.
// Write character and backspace pass through an execute state to the done state;
// read adds a capture state for the registered memory read. Clear blanks every
// cell, and a write or newline that leaves the last row copies the screen up a row
// and blanks the bottom row: one address counter walks the memory a cell per cycle,
// for clearing, for the row-up copy and for blanking the bottom row.
module text_console_writer_unit #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned LINE_MAX = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::CfgAw-1:0]     cfg_addr_i,
  input  logic [tcw_pkg::ColorW-1:0]    cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [tcw_pkg::OpW-1:0]       operation_i,
  input  logic [tcw_pkg::CodeW-1:0]     char_code_i,
  input  logic [tcw_pkg::IdxW-1:0]      cell_index_i,
  output logic                          done_o,
  output logic [tcw_pkg::PosW-1:0]      cursor_position_o,
  output logic [tcw_pkg::CellW-1:0]     cell_value_o,
  output logic [tcw_pkg::LenW-1:0]      line_length_o
);

  localparam int unsigned CellCount = ROWS * COLUMNS;
  localparam int unsigned CellAw    = $clog2(CellCount);
  localparam int unsigned ColW      = $clog2(COLUMNS);
  localparam int unsigned RowW      = $clog2(ROWS);
  localparam int unsigned CntW      = $clog2(LINE_MAX + 1);
  localparam int unsigned Copies    = CellCount - COLUMNS;

  localparam logic [CellAw-1:0] LastCell   = CellAw'(CellCount - 1);
  localparam logic [CellAw-1:0] LastCopy   = CellAw'(Copies - 1);
  localparam logic [CellAw-1:0] BottomBase = CellAw'(Copies);
  localparam logic [CellAw-1:0] RowStride  = CellAw'(COLUMNS);
  localparam logic [ColW-1:0]   LastCol    = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0]   LastRow    = RowW'(ROWS - 1);
  localparam logic [CntW-1:0]   CntMax     = CntW'(LINE_MAX);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_EXEC  = 9'b000000100,
    S_RDCAP = 9'b000001000,
    S_CLEAR = 9'b000010000,
    S_COPY  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_BLANK = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e                     state_q, state_d;
  logic [CellAw-1:0]          ptr_q, ptr_d;
  logic [ColW-1:0]            col_q, col_d;
  logic [RowW-1:0]            row_q, row_d;
  logic [CellAw-1:0]          pos_q, pos_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [tcw_pkg::ColorW-1:0] fg_q, bg_q;
  logic                       copy_wr_q, copy_wr_d;

  tcw_pkg::op_e               op_q;
  logic [tcw_pkg::CodeW-1:0]  code_q;
  logic [CellAw-1:0]          idx_q;
  logic                       idx_ok_q;
  logic [tcw_pkg::CellW-1:0]  value_q;
  logic [CellAw-1:0]          copy_addr_q;
  logic [tcw_pkg::CellW-1:0]  rdata_q;

  logic [tcw_pkg::CellW-1:0]  mem [CellCount];

  logic                       mem_we;
  logic [CellAw-1:0]          mem_waddr;
  logic [tcw_pkg::CellW-1:0]  mem_wdata;
  logic [CellAw-1:0]          mem_raddr;
  logic [tcw_pkg::CellW-1:0]  blank_cell;
  logic                       accept;

  assign accept     = start_i && (state_q == S_IDLE);
  assign blank_cell = {bg_q, fg_q, tcw_pkg::CodeBlank};
  assign mem_raddr  = (state_q == S_COPY) ? (ptr_q + RowStride) : idx_q;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    col_d     = col_q;
    row_d     = row_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    copy_wr_d = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = blank_cell;

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::CellReset;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == LastCell) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          tcw_pkg::OP_WRITE: begin
            if (code_q == tcw_pkg::CodeNewline) begin
              cnt_d = '0;
              col_d = '0;
              if (row_q == LastRow) begin
                state_d = S_COPY;
              end else begin
                row_d = row_q + 1'b1;
                pos_d = pos_q + (RowStride - CellAw'(col_q));
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pos_q;
              mem_wdata = {bg_q, fg_q, code_q};
              if (cnt_q != CntMax) begin
                cnt_d = cnt_q + 1'b1;
              end
              if (col_q == LastCol) begin
                col_d = '0;
                if (row_q == LastRow) begin
                  state_d = S_COPY;
                end else begin
                  row_d = row_q + 1'b1;
                  pos_d = pos_q + 1'b1;
                end
              end else begin
                col_d = col_q + 1'b1;
                pos_d = pos_q + 1'b1;
              end
            end
            if (state_d == S_COPY) begin
              ptr_d = '0;
              row_d = LastRow;
              col_d = '0;
              pos_d = BottomBase;
            end
          end
          tcw_pkg::OP_BACKSPACE: begin
            if (cnt_q != '0) begin
              cnt_d     = cnt_q - 1'b1;
              mem_we    = 1'b1;
              mem_waddr = pos_q;
              if (col_q != '0) begin
                col_d     = col_q - 1'b1;
                pos_d     = pos_q - 1'b1;
                mem_waddr = pos_q - 1'b1;
              end else if (row_q != '0) begin
                row_d     = row_q - 1'b1;
                col_d     = LastCol;
                pos_d     = pos_q - 1'b1;
                mem_waddr = pos_q - 1'b1;
              end
            end
          end
          tcw_pkg::OP_CLEAR: begin
            state_d = S_CLEAR;
            ptr_d   = '0;
            col_d   = '0;
            row_d   = '0;
            pos_d   = '0;
          end
          tcw_pkg::OP_READ: begin
            state_d = S_RDCAP;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RDCAP: begin
        state_d = S_DONE;
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == LastCell) begin
          state_d = S_DONE;
        end
      end
      S_COPY: begin
        // read one row ahead, write back in the next cycle
        copy_wr_d = 1'b1;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == LastCopy) begin
          state_d = S_DRAIN;
          ptr_d   = BottomBase;
        end
      end
      S_DRAIN: begin
        state_d = S_BLANK;
      end
      S_BLANK: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == LastCell) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // pending copy write owns the port
    if (copy_wr_q) begin
      mem_we    = 1'b1;
      mem_waddr = copy_addr_q;
      mem_wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      ptr_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      copy_wr_q <= 1'b0;
      fg_q      <= tcw_pkg::FgReset;
      bg_q      <= tcw_pkg::BgReset;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      col_q     <= col_d;
      row_q     <= row_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      copy_wr_q <= copy_wr_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          tcw_pkg::RegForeground: fg_q <= cfg_wdata_i;
          tcw_pkg::RegBackground: bg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= tcw_pkg::op_e'(operation_i);
      code_q   <= char_code_i;
      idx_q    <= CellAw'(cell_index_i);
      idx_ok_q <= 32'(cell_index_i) < 32'(CellCount);
      value_q  <= '0;
    end else if (state_q == S_RDCAP) begin
      value_q <= idx_ok_q ? rdata_q : '0;
    end
    copy_addr_q <= ptr_q;
  end

  // Screen store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = (state_q == S_DONE);
  assign cursor_position_o = tcw_pkg::PosW'(pos_q);
  assign cell_value_o      = value_q;
  assign line_length_o     = tcw_pkg::LenW'(cnt_q);

endmodule

@@ hdl/tcw_checker.sv @@
`timescale 1ns / 1ps

module tcw_checker #(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned LINE_MAX = 255
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic [tcw_pkg::PosW-1:0]  cursor_position_o,
  input logic [tcw_pkg::LenW-1:0]  line_length_o
);

  // a transfer always makes the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("transfer did not start an operation");

  // result strobe only while an operation is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");

  // one result per operation, then ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe not a single cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 32'(cursor_position_o) < ROWS * COLUMNS)
    else $error("cursor beyond screen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 32'(line_length_o) <= LINE_MAX)
    else $error("line length above limit");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS),
  .LINE_MAX(LINE_MAX)
) u_tcw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .cursor_position_o(cursor_position_o),
  .line_length_o    (line_length_o)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Cols        = 80;
  localparam int unsigned Rows        = 25;
  localparam int unsigned LineMax     = 255;
  localparam int unsigned Cells       = Cols * Rows;
  localparam int unsigned RandomItems = 1830;
  localparam int unsigned QuietLimit  = 20000;

  typedef struct packed {
    logic [tcw_pkg::PosW-1:0]  pos;
    logic [tcw_pkg::CellW-1:0] word;
    logic [tcw_pkg::LenW-1:0]  len;
  } console_result_t;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       cfg_we_i     = 1'b0;
  logic [tcw_pkg::CfgAw-1:0]  cfg_addr_i   = '0;
  logic [tcw_pkg::ColorW-1:0] cfg_wdata_i  = '0;
  logic                       start_i      = 1'b0;
  logic                       busy_o;
  logic [tcw_pkg::OpW-1:0]    operation_i  = '0;
  logic [tcw_pkg::CodeW-1:0]  char_code_i  = '0;
  logic [tcw_pkg::IdxW-1:0]   cell_index_i = '0;
  logic                       done_o;
  logic [tcw_pkg::PosW-1:0]   cursor_position_o;
  logic [tcw_pkg::CellW-1:0]  cell_value_o;
  logic [tcw_pkg::LenW-1:0]   line_length_o;

  // Predicted screen contents, cursor, echo count and colors
  logic [tcw_pkg::CellW-1:0]  screen_model [Cells];
  int unsigned                col_m  = 0;
  int unsigned                row_m  = 0;
  int unsigned                echo_m = 0;
  logic [tcw_pkg::ColorW-1:0] fg_m   = tcw_pkg::FgReset;
  logic [tcw_pkg::ColorW-1:0] bg_m   = tcw_pkg::BgReset;

  console_result_t   predicted_results [$];
  int unsigned       mismatches   = 0;
  int unsigned       items_sent   = 0;
  int unsigned       quiet_cycles = 0;
  bit                idle_enabled = 1'b0;

  always #5 clk_i = ~clk_i;

  text_console_writer_unit #(
    .COLUMNS (Cols),
    .ROWS    (Rows),
    .LINE_MAX(LineMax)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .char_code_i      (char_code_i),
    .cell_index_i     (cell_index_i),
    .done_o           (done_o),
    .cursor_position_o(cursor_position_o),
    .cell_value_o     (cell_value_o),
    .line_length_o    (line_length_o)
  );

  function automatic logic [tcw_pkg::CellW-1:0] colored(logic [tcw_pkg::CodeW-1:0] code);
    return {bg_m, fg_m, code};
  endfunction

  // Move to the next row start; past the last row shift everything up one row
  function automatic void advance_row();
    col_m = 0;
    row_m++;
    if (row_m >= Rows) begin
      for (int i = 0; i < Cells - Cols; i++) screen_model[i] = screen_model[i + Cols];
      for (int i = Cells - Cols; i < Cells; i++) screen_model[i] = colored(tcw_pkg::CodeBlank);
      row_m = Rows - 1;
    end
  endfunction

  function automatic console_result_t console_apply(tcw_pkg::op_e op,
                                                    logic [tcw_pkg::CodeW-1:0] code,
                                                    logic [tcw_pkg::IdxW-1:0] idx);
    console_result_t res;
    res.word = '0;
    case (op)
      tcw_pkg::OP_WRITE: begin
        if (code == tcw_pkg::CodeNewline) begin
          advance_row();
          echo_m = 0;
        end else begin
          screen_model[row_m * Cols + col_m] = colored(code);
          col_m++;
          if (col_m >= Cols) advance_row();
          if (echo_m < LineMax) echo_m++;
        end
      end
      tcw_pkg::OP_BACKSPACE: begin
        if (echo_m != 0) begin
          echo_m--;
          if (col_m > 0) begin
            col_m--;
          end else if (row_m > 0) begin
            row_m--;
            col_m = Cols - 1;
          end
          screen_model[row_m * Cols + col_m] = colored(tcw_pkg::CodeBlank);
        end
      end
      tcw_pkg::OP_CLEAR: begin
        for (int i = 0; i < Cells; i++) screen_model[i] = colored(tcw_pkg::CodeBlank);
        col_m = 0;
        row_m = 0;
      end
      default: begin
        if (idx < Cells) res.word = screen_model[idx];
      end
    endcase
    res.pos = tcw_pkg::PosW'(row_m * Cols + col_m);
    res.len = tcw_pkg::LenW'(echo_m);
    return res;
  endfunction

  function automatic void field_check(string field, logic [tcw_pkg::CellW-1:0] want,
                                      logic [tcw_pkg::CellW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // Result checker: the receiver takes every result at the edge that ends its cycle
  always @(posedge clk_i) begin
    console_result_t want;
    if (rst_ni && done_o) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected result, expected none actual pos=%0d cell=0x%0h len=%0d",
                   $time, cursor_position_o, cell_value_o, line_length_o);
      end else begin
        want = predicted_results.pop_front();
        field_check("cursor_position", tcw_pkg::CellW'(want.pos),
                    tcw_pkg::CellW'(cursor_position_o));
        field_check("cell_value", want.word, cell_value_o);
        field_check("line_length", tcw_pkg::CellW'(want.len),
                    tcw_pkg::CellW'(line_length_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold start high until the transfer; leave it high so a following item keeps it up
  task automatic send_op(tcw_pkg::op_e op, logic [tcw_pkg::CodeW-1:0] code,
                         logic [tcw_pkg::IdxW-1:0] idx);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    operation_i  <= op;
    char_code_i  <= code;
    cell_index_i <= idx;
    do @(posedge clk_i); while (busy_o);
    predicted_results.push_back(console_apply(op, code, idx));
    items_sent++;
  endtask

  task automatic type_char(logic [tcw_pkg::CodeW-1:0] code);
    send_op(tcw_pkg::OP_WRITE, code, tcw_pkg::IdxW'($urandom));
  endtask

  task automatic erase();
    send_op(tcw_pkg::OP_BACKSPACE, tcw_pkg::CodeW'($urandom), tcw_pkg::IdxW'($urandom));
  endtask

  task automatic wipe_screen();
    send_op(tcw_pkg::OP_CLEAR, tcw_pkg::CodeW'($urandom), tcw_pkg::IdxW'($urandom));
  endtask

  task automatic peek(int unsigned idx);
    send_op(tcw_pkg::OP_READ, tcw_pkg::CodeW'($urandom), tcw_pkg::IdxW'(idx));
  endtask

  // Drop start and let every outstanding result come back
  task automatic wait_drained();
    start_i <= 1'b0;
    while (predicted_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drive the write until a clock edge takes it, then drop the enable ahead of the next write
  task automatic write_color(logic [tcw_pkg::CfgAw-1:0] index,
                             logic [tcw_pkg::ColorW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == tcw_pkg::RegForeground) fg_m = value;
    else bg_m = value;
    @(posedge clk_i);
  endtask

  task automatic test_power_on_screen();
    peek(0);
    peek(Cells - 1);
    peek(Cells);
    peek(2047);
    erase();  // nothing echoed yet: no change
  endtask

  task automatic test_character_codes();
    wait_drained();
    write_color(tcw_pkg::RegForeground, 4'h0);
    write_color(tcw_pkg::RegBackground, 4'hF);
    type_char(8'h00);
    type_char(8'hFF);
    type_char(8'h08);  // stored as a character, not a backspace
    type_char(8'h80);
    type_char(tcw_pkg::CodeNewline);
    peek(0);
    peek(1);
    peek(2);
    peek(3);
    peek(Cols);
  endtask

  task automatic test_backspace_cases();
    type_char(8'h41);
    type_char(8'h42);
    erase();
    peek(Cols + 1);
    wipe_screen();  // keeps the echo count
    erase();        // at home: blank the home cell, cursor stays
    erase();
    peek(0);
  endtask

  task automatic run_phase(logic [tcw_pkg::ColorW-1:0] fg, logic [tcw_pkg::ColorW-1:0] bg,
                           int unsigned items, bit idle, bit long_line);
    int unsigned  stop_at;
    int unsigned  n;
    int unsigned  kind;
    int           p;
    tcw_pkg::op_e op;
    wait_drained();
    write_color(tcw_pkg::RegForeground, fg);
    write_color(tcw_pkg::RegBackground, bg);
    idle_enabled = idle;
    stop_at = items_sent + items;
    // Run past the echo limit once, then back off it
    if (long_line) begin
      n = $urandom_range(256, 262);
      for (int i = 0; i < n; i++) type_char(tcw_pkg::CodeW'($urandom_range(32, 126)));
      erase();
      erase();
    end
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 20);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) erase();
          else if ($urandom_range(0, 4) == 0) type_char(tcw_pkg::CodeW'($urandom));
          else type_char(tcw_pkg::CodeW'($urandom_range(32, 126)));
        end
        if ($urandom_range(0, 4) != 0) type_char(tcw_pkg::CodeNewline);
      end else if (kind < 50) begin
        // Fill to the row end, then back up across the wrap
        n = Cols - col_m;
        for (int i = 0; i < n; i++) type_char(tcw_pkg::CodeW'($urandom));
        repeat ($urandom_range(1, 3)) erase();
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 4))
            0: peek($urandom_range(0, 2047));
            1: peek($urandom_range(Cells, 2047));
            2: begin
              p = int'(row_m * Cols + col_m) - int'($urandom_range(0, 3));
              peek((p < 0) ? 0 : p);
            end
            3: peek($urandom_range(0, Rows - 1) * Cols + ($urandom_range(0, 1) ? 0 : Cols - 1));
            default: peek($urandom_range(0, Cells - 1));
          endcase
        end
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 8)) erase();
      end else if (kind < 83) begin
        repeat ($urandom_range(1, 8)) type_char(tcw_pkg::CodeNewline);
      end else if (kind < 84) begin
        wipe_screen();
      end else begin
        // Noise: any field values; clears kept rare since each walks the store
        repeat ($urandom_range(1, 4)) begin
          op = tcw_pkg::op_e'($urandom_range(0, 3));
          if (op == tcw_pkg::OP_CLEAR && $urandom_range(0, 7) != 0) op = tcw_pkg::OP_READ;
          send_op(op, tcw_pkg::CodeW'($urandom), tcw_pkg::IdxW'($urandom));
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned per_phase;
    per_phase = RandomItems / 6;
    run_phase(4'hF, 4'h0, per_phase, 1'b1, 1'b0);
    run_phase(4'h0, 4'hF, per_phase, 1'b1, 1'b1);
    run_phase(tcw_pkg::ColorW'($urandom), tcw_pkg::ColorW'($urandom), per_phase, 1'b1, 1'b0);
    run_phase(4'h0, 4'h0, per_phase, 1'b1, 1'b1);
    run_phase(4'hF, 4'hF, per_phase, 1'b1, 1'b0);
    run_phase(tcw_pkg::ColorW'($urandom), tcw_pkg::ColorW'($urandom), per_phase, 1'b0, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < Cells; i++) screen_model[i] = tcw_pkg::CellReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    test_power_on_screen();
    test_character_codes();
    test_backspace_cases();
    test_random_traffic();
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
